// ===== hdl/fspa_pkg.sv =====
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared types and codes for the fixed slot pool allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

	localparam int ADDR_W = 14;
	localparam int SIZE_W = 13;
	localparam int STAT_W = 2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_PAGES = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

	localparam logic [SIZE_W-1:0] SLOT_SIZE_RST = 13'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POPW,
		ST_CARVE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] granted;
		logic [STAT_W-1:0] status;
	} result_t;

endpackage

// ===== hdl/fixed_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator
// Fixed-size slot allocator over MAX_PAGES pages, backed by a free-address
// stack in RAM that is refilled one page at a time.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ---------------------------------
//  input     in_valid / in_stall    command, slot_address
//  output    out_valid / out_stall  granted_address, status
//  config    slot_size_we           slot_size
//
//  Flow: a free or an error is staged in ST_RESULT; a pop from a non-empty
//  stack reads the RAM in ST_POPW. An allocate on an empty stack carves a page:
//  one RAM write per slot through the shared offset adder, floor(PAGE_BYTES /
//  slot_size) writes in all, paced by the single RAM write port.
//  Reset: arst_n clears the stack count, page count and slot size (to 8).
//  The stack RAM is not cleared; only pushed entries are ever read.
//  Stalls: the output register holds a result while out_stall is high; the
//  input is stalled whenever an item is in work.
//
module fixed_slot_pool_allocator #(
	parameter int PAGE_BYTES  = 4096,
	parameter int MAX_PAGES   = 4,
	parameter int STACK_DEPTH = 16384
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        slot_size_we,
	input  logic [fspa_pkg::SIZE_W-1:0] slot_size,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic [fspa_pkg::ADDR_W-1:0] slot_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fspa_pkg::ADDR_W-1:0] granted_address,
	output logic [fspa_pkg::STAT_W-1:0] status
);

	import fspa_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);

	logic [SIZE_W-1:0] slot_size_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ADDR_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [ADDR_W-1:0] ram_rdata;

	logic              res_valid;
	logic              res_take;
	result_t           res;

	logic              out_valid_q;
	result_t           out_q;

	// slot size register: the registered value feeds the page checks and the carve step, also a carve in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_size_q <= SLOT_SIZE_RST;
		end else if (slot_size_we) begin
			slot_size_q <= slot_size;
		end
	end

	fspa_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fspa_ctrl #(
		.PAGE_BYTES  (PAGE_BYTES),
		.MAX_PAGES   (MAX_PAGES),
		.STACK_DEPTH (STACK_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.slot_address (slot_address),
		.slot_size    (slot_size_q),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res)
	);

	// output register: take a new result when empty or when the current one
	// transfers in this cycle
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign granted_address = out_q.granted;
	assign status          = out_q.status;

	// an accepted item keeps the input stalled until its result is staged
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in consecutive cycles");

	// an error result never carries an address
	a_err_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || granted_address == '0))
		else $error("error result with nonzero granted address");

	// the stack RAM is never read and written in the same cycle
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("stack RAM read and write collide");

endmodule

// ===== hdl/fspa_ram.sv =====
// ----------------------------------------------------------------------------
// fspa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fspa_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/fspa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fspa_ctrl
// Sequencer for the allocator: stack pointer, page carving with one shared
// offset adder, and result staging.
// ----------------------------------------------------------------------------
module fspa_ctrl #(
	parameter int PAGE_BYTES  = 4096,
	parameter int MAX_PAGES   = 4,
	parameter int STACK_DEPTH = 16384
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [fspa_pkg::ADDR_W-1:0]     slot_address,
	input  logic [fspa_pkg::SIZE_W-1:0]     slot_size,
	output logic                            ram_we,
	output logic [$clog2(STACK_DEPTH)-1:0]  ram_waddr,
	output logic [fspa_pkg::ADDR_W-1:0]     ram_wdata,
	output logic                            ram_re,
	output logic [$clog2(STACK_DEPTH)-1:0]  ram_raddr,
	input  logic [fspa_pkg::ADDR_W-1:0]     ram_rdata,
	output logic                            res_valid,
	input  logic                            res_take,
	output fspa_pkg::result_t               res
);

	import fspa_pkg::*;

	localparam int AW     = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int PG_W   = $clog2(MAX_PAGES + 1);
	localparam int OFF_W  = (($clog2(PAGE_BYTES) > SIZE_W) ? $clog2(PAGE_BYTES) : SIZE_W) + 2;
	// a slot size at or below this gives more slots per page than the stack holds
	localparam int FULL_LIM = PAGE_BYTES / (STACK_DEPTH + 1);

	localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(STACK_DEPTH);
	localparam logic [PG_W-1:0]   PAGES_C   = PG_W'(MAX_PAGES);
	localparam logic [OFF_W-1:0]  PAGE_LIM  = OFF_W'(PAGE_BYTES);
	localparam logic [OFF_W-1:0]  FULL_C    = OFF_W'(FULL_LIM);
	localparam logic [ADDR_W-1:0] PAGE_STEP = ADDR_W'(PAGE_BYTES);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [PG_W-1:0]   pages_q, pages_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic [OFF_W-1:0]  off_q, off_d;
	result_t           res_q, res_d;

	logic [OFF_W-1:0]  size_ext;
	logic [OFF_W-1:0]  off_nxt;
	logic              carve_last;
	logic [ADDR_W-1:0] carve_addr;
	logic [CNT_W-1:0]  count_m1;

	// a slot size of zero acts as one
	assign size_ext   = (slot_size == '0) ? OFF_W'(1) : OFF_W'(slot_size);
	assign off_nxt    = off_q + size_ext;
	assign carve_last = (off_nxt + size_ext) > PAGE_LIM;
	assign carve_addr = base_q + off_q[ADDR_W-1:0];
	assign count_m1   = count_q - CNT_W'(1);

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_POPW) || (state_q == ST_RESULT);
	assign res       = (state_q == ST_POPW) ? result_t'{granted: ram_rdata, status: STAT_OK}
	                                        : res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pages_q <= '0;
			base_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pages_q <= pages_d;
			base_q  <= base_d;
		end
	end

	always_ff @(posedge clk) begin
		off_q <= off_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pages_d   = pages_q;
		base_d    = base_q;
		off_d     = off_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = slot_address;
		ram_raddr = count_m1[AW-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == CMD_FREE) begin
						if (count_q >= DEPTH_C) begin
							res_d = '{granted: '0, status: STAT_FULL};
						end else begin
							ram_we  = 1'b1;
							count_d = count_q + CNT_W'(1);
							res_d   = '{granted: '0, status: STAT_OK};
						end
						state_d = ST_RESULT;
					end else if (count_q != '0) begin
						ram_re  = 1'b1;
						count_d = count_m1;
						state_d = ST_POPW;
					end else if ((pages_q >= PAGES_C) || (size_ext > PAGE_LIM)) begin
						res_d   = '{granted: '0, status: STAT_NO_PAGES};
						state_d = ST_RESULT;
					end else if (size_ext <= FULL_C) begin
						res_d   = '{granted: '0, status: STAT_FULL};
						state_d = ST_RESULT;
					end else begin
						off_d   = '0;
						state_d = ST_CARVE;
					end
				end
			end
			ST_POPW: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			ST_CARVE: begin
				ram_we    = 1'b1;
				ram_wdata = carve_addr;
				if (carve_last) begin
					// top slot goes straight out; its entry is written but not counted
					res_d   = '{granted: carve_addr, status: STAT_OK};
					pages_d = pages_q + PG_W'(1);
					base_d  = base_q + PAGE_STEP;
					state_d = ST_RESULT;
				end else begin
					count_d = count_q + CNT_W'(1);
					off_d   = off_nxt;
				end
			end
			ST_RESULT: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== tb/tb_fixed_slot_pool_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_slot_pool_allocator
// Self-checking bench for the slot pool allocator. A directed table covers
// oversized slots, extreme addresses, slot size changes and duplicate frees.
// Random alloc/free traffic follows under several slot sizes. A final pass
// uses up every page, then checks allocates with no page left to carve, at a
// zero slot size too. Each result is compared to a bench-side model of the
// stack or to a result written out with the request.
// ----------------------------------------------------------------------------
module tb_fixed_slot_pool_allocator;
	import fspa_pkg::*;

	localparam int PAGE_BYTES  = 4096;
	localparam int MAX_PAGES   = 4;
	localparam int STACK_DEPTH = 16384;

	// kind of one row in the directed table
	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// has_lit marks rows whose result is written out below instead of predicted
	typedef struct packed {
		row_kind_t         kind;
		logic              cmd;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
		logic              has_lit;
		result_t           lit;
	} stim_row_t;

	localparam stim_row_t DIRECTED_ROWS [21] = '{
		// slots wider than a page: nothing fits, no page is used up
		'{ROW_CFG,  CMD_ALLOC, 14'h0000, 13'd4097, 1'b0, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_ALLOC, 14'h3FFF, 13'd0,    1'b1, '{14'h0000, STAT_NO_PAGES}},
		'{ROW_CFG,  CMD_ALLOC, 14'h0000, 13'd8191, 1'b0, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_ALLOC, 14'h0000, 13'd0,    1'b1, '{14'h0000, STAT_NO_PAGES}},
		// one slot per page: page 0 yields address 0
		'{ROW_CFG,  CMD_ALLOC, 14'h0000, 13'd4096, 1'b0, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_ALLOC, 14'h0000, 13'd0,    1'b1, '{14'h0000, STAT_OK}},
		// frees of extreme and alternating addresses
		'{ROW_ITEM, CMD_FREE,  14'h3FFF, 13'd0,    1'b1, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_FREE,  14'h0000, 13'd0,    1'b1, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_FREE,  14'h2AAA, 13'd0,    1'b1, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_FREE,  14'h1555, 13'd0,    1'b1, '{14'h0000, STAT_OK}},
		// new size with slots still stacked: they keep their addresses
		'{ROW_CFG,  CMD_ALLOC, 14'h0000, 13'd64,   1'b0, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_ALLOC, 14'h0000, 13'd0,    1'b0, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_ALLOC, 14'h3FFF, 13'd0,    1'b0, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_ALLOC, 14'h0000, 13'd0,    1'b0, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_ALLOC, 14'h3FFF, 13'd0,    1'b0, '{14'h0000, STAT_OK}},
		// duplicate free comes back twice
		'{ROW_ITEM, CMD_FREE,  14'h2AAA, 13'd0,    1'b1, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_FREE,  14'h2AAA, 13'd0,    1'b1, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_ALLOC, 14'h0000, 13'd0,    1'b0, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_ALLOC, 14'h0000, 13'd0,    1'b0, '{14'h0000, STAT_OK}},
		// empty again: carve page 1 at the new size
		'{ROW_ITEM, CMD_ALLOC, 14'h0000, 13'd0,    1'b0, '{14'h0000, STAT_OK}},
		'{ROW_ITEM, CMD_ALLOC, 14'h0000, 13'd0,    1'b0, '{14'h0000, STAT_OK}}
	};

	logic              clk             = 1'b0;
	logic              arst_n          = 1'b0;
	logic              slot_size_we    = 1'b0;
	logic [SIZE_W-1:0] slot_size       = '0;
	logic              in_valid        = 1'b0;
	logic              in_stall;
	logic              command         = CMD_ALLOC;
	logic [ADDR_W-1:0] slot_address    = '0;
	logic              out_valid;
	logic              out_stall       = 1'b0;
	logic [ADDR_W-1:0] granted_address;
	logic [STAT_W-1:0] status;

	// bench copy of the allocator state
	logic [ADDR_W-1:0] pool_stack [STACK_DEPTH];
	int unsigned       pool_count  = 0;
	int unsigned       pages_carved = 0;
	logic [SIZE_W-1:0] pool_slot_size = SLOT_SIZE_RST;

	result_t           pending_results[$];
	logic [ADDR_W-1:0] live_slots[$];
	int                error_count = 0;
	int                sent_count  = 0;
	int                taken_count = 0;
	bit                send_gaps   = 1'b1;
	bit                take_gaps   = 1'b1;

	fixed_slot_pool_allocator #(
		.PAGE_BYTES (PAGE_BYTES),
		.MAX_PAGES  (MAX_PAGES),
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.slot_size_we   (slot_size_we),
		.slot_size      (slot_size),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.slot_address   (slot_address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted_address(granted_address),
		.status         (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop; sized well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		// count every mismatch, but keep the log readable on a broken build
		if (error_count <= 100)
			$display("ERROR %0t ns: %s", $time, msg);
	endtask

	// Advance the bench allocator by one transfer and return its result.
	function automatic result_t carve_or_pop(input logic cmd, input logic [ADDR_W-1:0] addr);
		result_t     res;
		int unsigned eff_size;
		int unsigned per_page;
		int unsigned page_base;
		int unsigned i;
		res.granted = '0;
		res.status  = STAT_OK;
		if (cmd == CMD_ALLOC) begin
			if (pool_count == 0) begin
				// a zero size behaves as one byte per slot
				eff_size = (pool_slot_size == 0) ? 1 : pool_slot_size;
				per_page = PAGE_BYTES / eff_size;
				if (pages_carved >= MAX_PAGES || per_page == 0) begin
					res.status = STAT_NO_PAGES;
				end else if (per_page > STACK_DEPTH - pool_count) begin
					res.status = STAT_FULL;
				end else begin
					// push slots low to high, so the highest pops first
					page_base = pages_carved * PAGE_BYTES;
					for (i = 0; i < per_page; i++) begin
						pool_stack[pool_count] = ADDR_W'(page_base + i * eff_size);
						pool_count++;
					end
					pages_carved++;
				end
			end
			if (res.status == STAT_OK && pool_count > 0) begin
				pool_count--;
				res.granted = pool_stack[pool_count];
			end
		end else begin
			// free is unchecked; drop it only when the stack is full
			if (pool_count >= STACK_DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				pool_stack[pool_count] = addr;
				pool_count++;
			end
		end
		return res;
	endfunction

	// Present one request, hold it until the transfer, then log its result.
	task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] addr,
			input logic has_lit, input result_t lit);
		int      gap;
		result_t predicted;
		gap = send_gaps ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		slot_address <= addr;
		do @(posedge clk); while (in_stall);
		predicted = carve_or_pop(cmd, addr);
		pending_results.push_back(has_lit ? lit : predicted);
		if (cmd == CMD_ALLOC && predicted.status == STAT_OK)
			live_slots.push_back(predicted.granted);
		sent_count++;
		// switch between gapped and back-to-back stretches
		if (sent_count % 64 == 0)
			send_gaps = ($urandom_range(0, 3) != 0);
	endtask

	// Drop valid, drain every pending result, then write the slot size.
	task automatic write_slot_size(input logic [SIZE_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		slot_size_we <= 1'b1;
		slot_size    <= value;
		@(posedge clk);
		slot_size_we <= 1'b0;
		pool_slot_size = value;
	endtask

	// Result side: stall at random, then check each transfer in order.
	initial begin
		int      hold;
		result_t want;
		wait (arst_n === 1'b1);
		forever begin
			hold = take_gaps ? $urandom_range(0, 10) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with none pending: addr %0h status %0d",
					granted_address, status));
			end else begin
				want = pending_results.pop_front();
				if (granted_address !== want.granted)
					report_mismatch($sformatf("granted_address %0h, want %0h",
						granted_address, want.granted));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", status, want.status));
			end
			taken_count++;
			if (taken_count % 64 == 0)
				take_gaps = ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		int                phase;
		int                k;
		int                pick;
		int                idx;
		int unsigned       eff_size;
		logic [SIZE_W-1:0] size_pick;
		logic [ADDR_W-1:0] addr;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].kind == ROW_CFG)
				write_slot_size(DIRECTED_ROWS[r].size);
			else
				send_request(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].addr,
					DIRECTED_ROWS[r].has_lit, DIRECTED_ROWS[r].lit);
		end

		// Random traffic in phases, each under a fresh slot size. Most frees
		// return a slot that was handed out; the rest are duplicates or foreign.
		// Small sizes stop at 16 bytes so one carve stays within 256 slots.
		for (phase = 0; phase < 6; phase++) begin
			case ($urandom_range(0, 5))
				0:       size_pick = SIZE_W'(PAGE_BYTES);
				1:       size_pick = SIZE_W'($urandom_range(PAGE_BYTES + 1, 8191));
				2:       size_pick = SIZE_W'($urandom_range(16, 64));
				3:       size_pick = SIZE_W'($urandom_range(17, 512));
				4:       size_pick = SIZE_W'($urandom_range(513, PAGE_BYTES - 1));
				default: size_pick = 13'd8191;
			endcase
			write_slot_size(size_pick);
			for (k = 0; k < 250; k++) begin
				eff_size = (pool_slot_size == 0) ? 1 : pool_slot_size;
				// hold back the last page for the exhaustion pass below
				if ($urandom_range(0, 99) < 55 && !(pool_count == 0 &&
						pages_carved >= MAX_PAGES - 1 && PAGE_BYTES / eff_size != 0)) begin
					send_request(CMD_ALLOC, ADDR_W'($urandom), 1'b0, '0);
				end else begin
					pick = $urandom_range(0, 9);
					if (live_slots.size() != 0 && pick < 7) begin
						idx  = $urandom_range(0, live_slots.size() - 1);
						addr = live_slots[idx];
						live_slots.delete(idx);
					end else if (live_slots.size() != 0 && pick < 8) begin
						addr = live_slots[$urandom_range(0, live_slots.size() - 1)];
					end else begin
						addr = ADDR_W'($urandom);
					end
					send_request(CMD_FREE, addr, 1'b0, '0);
				end
			end
		end

		// Use up all pages but the last, one slot at a time.
		write_slot_size(SIZE_W'(PAGE_BYTES));
		while (!(pool_count == 0 && pages_carved == MAX_PAGES - 1))
			send_request(CMD_ALLOC, ADDR_W'($urandom), 1'b0, '0);

		// the last page holds a single slot at its base
		send_request(CMD_ALLOC, '0, 1'b1, '{14'h3000, STAT_OK});

		// pages exhausted
		repeat (3) send_request(CMD_ALLOC, ADDR_W'($urandom), 1'b1, '{14'h0000, STAT_NO_PAGES});
		send_request(CMD_FREE, 14'h1555, 1'b1, '{14'h0000, STAT_OK});
		send_request(CMD_ALLOC, '0, 1'b0, '0);
		send_request(CMD_ALLOC, '0, 1'b1, '{14'h0000, STAT_NO_PAGES});

		// a zero size finds no page left to carve either
		write_slot_size('0);
		send_request(CMD_ALLOC, '0, 1'b1, '{14'h0000, STAT_NO_PAGES});
		send_request(CMD_FREE, 14'h3FFF, 1'b1, '{14'h0000, STAT_OK});
		send_request(CMD_ALLOC, '0, 1'b1, '{14'h3FFF, STAT_OK});
		send_request(CMD_ALLOC, '0, 1'b1, '{14'h0000, STAT_NO_PAGES});

		// drain, then leave room for any stray late result
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
